// ===== rtl/core/cgl_pkg.sv =====
// package for the color gradient lookup block
// constants, request codes and status codes, no dependencies
package cgl_pkg;
   localparam int MaxStops = 16;
   localparam logic [15:0] DefPos = 16'd32768;
   localparam logic [7:0] DefRed = 8'd255;
   localparam logic [7:0] DefGreen = 8'd68;
   localparam logic [7:0] DefBlue = 8'd26;

   typedef enum logic [1:0] {
      REQ_LOOKUP = 2'd0,
      REQ_INSERT = 2'd1,
      REQ_REMOVE = 2'd2,
      REQ_RESET = 2'd3
   } req_type_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_FULL = 2'd1,
      ST_BAD_INDEX = 2'd2
   } status_type;
endpackage

// ===== rtl/core/color_gradient_lookup.sv =====
// color gradient lookup: sorted table of rgb stops held in one synchronous memory
// depends on cgl_pkg for sizes, the default stop and the request and status codes
//
// One transaction at a time: a request is taken at a rising edge with start high and
// busy low. Its single result is on the rsp_ ports for exactly one cycle, marked by
// rsp_valid, in the cycle in which busy falls; the receiver cannot stall. The
// busy time is set by the stop memory, one write port and one registered read port.
// - Lookup: reads and then checks each stop in turn from entry 0. Interpolation then
//   forms the product, the eight quotient bits for all three channels at once, and
//   the sum.
// - Insert: walks down from the top stop and moves each higher stop up one slot, with
//   a read and a check per stop examined. S_INS_PUT writes the new stop when it lands
//   at entry 0.
// - Remove: moves each stop above the index down, with a read and a write per stop.
// - A rejected insert or remove, removing the top stop or the only stop (which stays),
//   and reset to default go straight to S_DONE or S_DEF before the result.
// After reset the block is busy in S_INIT while it writes the default stop.
module color_gradient_lookup #(
   parameter int MAX_STOPS = cgl_pkg::MaxStops
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_position,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic [3:0]  req_entry_index,
   output logic        rsp_valid,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_point_count
);
   localparam int AW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
   localparam int CW = $clog2(MAX_STOPS + 1);
   localparam logic [39:0] DefStop = {cgl_pkg::DefPos, cgl_pkg::DefRed,
                                      cgl_pkg::DefGreen, cgl_pkg::DefBlue};

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_LK_RD, S_LK_CHK, S_MUL, S_DIV, S_FIN,
      S_INS_RD, S_INS_CHK, S_INS_PUT, S_RM_RD, S_RM_WR, S_DEF, S_DONE
   } state_type;

   // entry: pos, r, g, b
   logic [39:0]   mem [MAX_STOPS];
   logic [39:0]   rd_ff;
   logic          we;
   logic [AW-1:0] waddr, raddr;
   logic [39:0]   wdata;

   state_type     state_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] ptr_ff;       // entry being read
   logic [39:0]   new_ff;       // request position and color
   logic [39:0]   prev_ff;      // lower stop of the bracket
   logic [39:0]   hi_ff;        // upper stop of the bracket
   logic [15:0]   num_ff, den_ff;
   logic [15:0]   rem_ff [3];
   logic [7:0]    lo_ff [3];
   logic [7:0]    q_ff [3];
   logic [2:0]    bit_ff;
   logic [7:0]    r_ff, g_ff, b_ff;
   logic [1:0]    st_ff;
   logic          valid_ff;

   logic [7:0]    ca [3], cb [3], dlt [3];
   logic          rising [3];
   logic [23:0]   prod [3];
   logic [17:0]   trial [3];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   assign raddr = ptr_ff[AW-1:0];

   // per channel: delta * num, then a restoring divide; the quotient is below 256,
   // so the upper 16 product bits already form the starting remainder
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ca[k] = prev_ff[23-8*k -: 8];
         cb[k] = hi_ff[23-8*k -: 8];
         rising[k] = (cb[k] >= ca[k]);
         dlt[k] = rising[k] ? cb[k] - ca[k] : ca[k] - cb[k];
         prod[k] = 24'(dlt[k]) * 24'(num_ff);
         trial[k] = {1'b0, rem_ff[k], lo_ff[k][7]} - {2'b00, den_ff};
      end
   end

   always_comb begin
      we = 1'b0;
      waddr = '0;
      wdata = rd_ff;
      case (state_ff)
         S_INIT, S_DEF: begin
            we = 1'b1;
            wdata = DefStop;
         end
         // higher stop moves up, or the new stop lands above the lower one
         S_INS_CHK: begin
            we = 1'b1;
            waddr = AW'(ptr_ff + CW'(1));
            wdata = (rd_ff[39:24] > new_ff[39:24]) ? rd_ff : new_ff;
         end
         S_INS_PUT: begin
            we = 1'b1;
            wdata = new_ff;
         end
         S_RM_WR: begin
            we = 1'b1;
            waddr = AW'(ptr_ff - CW'(1));
         end
         default: we = 1'b0;
      endcase
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_red = r_ff;
   assign rsp_green = g_ff;
   assign rsp_blue = b_ff;
   assign rsp_status = st_ff;
   assign rsp_point_count = 5'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         count_ff <= CW'(1);
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= 1'b0;
         case (state_ff)
            S_INIT: state_ff <= S_IDLE;
            S_IDLE: begin
               if (start) begin
                  new_ff <= {req_position, req_red, req_green, req_blue};
                  r_ff <= '0;
                  g_ff <= '0;
                  b_ff <= '0;
                  st_ff <= cgl_pkg::ST_OK;
                  case (cgl_pkg::req_type_type'(req_type))
                     cgl_pkg::REQ_LOOKUP: begin
                        ptr_ff <= '0;
                        state_ff <= S_LK_RD;
                     end
                     cgl_pkg::REQ_INSERT: begin
                        if (32'(count_ff) >= MAX_STOPS) begin
                           st_ff <= cgl_pkg::ST_FULL;
                           state_ff <= S_DONE;
                        end else begin
                           ptr_ff <= count_ff - CW'(1);
                           state_ff <= S_INS_RD;
                        end
                     end
                     cgl_pkg::REQ_REMOVE: begin
                        if (32'(req_entry_index) >= 32'(count_ff)) begin
                           st_ff <= cgl_pkg::ST_BAD_INDEX;
                           state_ff <= S_DONE;
                        end else if (count_ff == CW'(1)) begin
                           state_ff <= S_DONE;
                        end else if (32'(req_entry_index) + 32'd1 == 32'(count_ff)) begin
                           // top stop: nothing to move
                           count_ff <= count_ff - CW'(1);
                           state_ff <= S_DONE;
                        end else begin
                           ptr_ff <= CW'(req_entry_index) + CW'(1);
                           state_ff <= S_RM_RD;
                        end
                     end
                     default: state_ff <= S_DEF;
                  endcase
               end
            end
            S_LK_RD: state_ff <= S_LK_CHK;
            S_LK_CHK: begin
               if (ptr_ff != '0 && new_ff[39:24] < rd_ff[39:24]) begin
                  // bracket: previous stop at or below pos, this one above
                  hi_ff <= rd_ff;
                  num_ff <= new_ff[39:24] - prev_ff[39:24];
                  den_ff <= rd_ff[39:24] - prev_ff[39:24];
                  state_ff <= S_MUL;
               end else if ((ptr_ff == '0 && new_ff[39:24] <= rd_ff[39:24]) ||
                            ptr_ff == count_ff - CW'(1)) begin
                  // at or below the first stop, or at or past the last
                  {r_ff, g_ff, b_ff} <= rd_ff[23:0];
                  valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  prev_ff <= rd_ff;
                  ptr_ff <= ptr_ff + CW'(1);
                  state_ff <= S_LK_RD;
               end
            end
            S_MUL: begin
               for (int k = 0; k < 3; k++) begin
                  rem_ff[k] <= prod[k][23:8];
                  lo_ff[k] <= prod[k][7:0];
                  q_ff[k] <= '0;
               end
               bit_ff <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               for (int k = 0; k < 3; k++) begin
                  if (!trial[k][17]) begin
                     rem_ff[k] <= trial[k][15:0];
                     q_ff[k] <= {q_ff[k][6:0], 1'b1};
                  end else begin
                     rem_ff[k] <= {rem_ff[k][14:0], lo_ff[k][7]};
                     q_ff[k] <= {q_ff[k][6:0], 1'b0};
                  end
                  lo_ff[k] <= {lo_ff[k][6:0], 1'b0};
               end
               bit_ff <= bit_ff + 3'd1;
               if (bit_ff == 3'd7) state_ff <= S_FIN;
            end
            S_FIN: begin
               r_ff <= rising[0] ? ca[0] + q_ff[0] : ca[0] - q_ff[0];
               g_ff <= rising[1] ? ca[1] + q_ff[1] : ca[1] - q_ff[1];
               b_ff <= rising[2] ? ca[2] + q_ff[2] : ca[2] - q_ff[2];
               valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            S_INS_RD: state_ff <= S_INS_CHK;
            S_INS_CHK: begin
               if (rd_ff[39:24] > new_ff[39:24]) begin
                  if (ptr_ff == '0) state_ff <= S_INS_PUT;
                  else begin
                     ptr_ff <= ptr_ff - CW'(1);
                     state_ff <= S_INS_RD;
                  end
               end else begin
                  count_ff <= count_ff + CW'(1);
                  valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            S_INS_PUT: begin
               count_ff <= count_ff + CW'(1);
               valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            S_RM_RD: state_ff <= S_RM_WR;
            S_RM_WR: begin
               if (ptr_ff == count_ff - CW'(1)) begin
                  count_ff <= count_ff - CW'(1);
                  valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  ptr_ff <= ptr_ff + CW'(1);
                  state_ff <= S_RM_RD;
               end
            end
            S_DEF: begin
               count_ff <= CW'(1);
               valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            S_DONE: begin
               valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_busy_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double result");
   a_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CW'(1)) && (32'(count_ff) <= MAX_STOPS)) else $error("bad stop count");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("transaction not taken");
endmodule
